FILE: src/xsfb_pkg.sv
// Shared types and constants for the XOR sprite framebuffer.
package xsfb_pkg;

	localparam int FRAME_WIDTH_DEF  = 64;
	localparam int FRAME_HEIGHT_DEF = 32;

	localparam int OP_W     = 2;
	localparam int COORD_W  = 8;
	localparam int COORD_N  = 2 ** COORD_W;
	localparam int OFFSET_W = 4;
	localparam int SPRITE_W = 8;
	localparam int PIXELS_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

endpackage

FILE: src/xsfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xsfb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/xsfb_addr.sv
// Row address and toggle mask generation with modulo wrap of both coordinates.
module xsfb_addr import xsfb_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  op_t                             operation,
	input  logic [COORD_W-1:0]              column,
	input  logic [COORD_W-1:0]              base_row,
	input  logic [OFFSET_W-1:0]             row_offset,
	input  logic [SPRITE_W-1:0]             sprite_bits,
	output logic [$clog2(FRAME_HEIGHT)-1:0] row,
	output logic [FRAME_WIDTH-1:0]          mask
);

	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int SUM_W = ROW_W + 2;
	localparam int POS_W = COL_W + 1;

	logic [ROW_W-1:0] row_tbl [COORD_N];
	logic [COL_W-1:0] col_tbl [COORD_N];

	// Build constant modulo tables for the 8-bit coordinates
	for (genvar i = 0; i < COORD_N; i++) begin : g_tbl
		assign row_tbl[i] = ROW_W'(i % FRAME_HEIGHT);
		assign col_tbl[i] = COL_W'(i % FRAME_WIDTH);
	end

	logic [ROW_W-1:0] base_mod;
	logic [SUM_W-1:0] off_w;
	logic [SUM_W-1:0] off_mod;
	logic [SUM_W-1:0] row_sum;
	logic [SUM_W-1:0] row_wrap;

	// Base row wraps by table, offset and sum by one compare-subtract each
	always_comb begin
		base_mod = row_tbl[base_row];
		off_w    = SUM_W'(row_offset);
		off_mod  = (off_w >= SUM_W'(FRAME_HEIGHT)) ? off_w - SUM_W'(FRAME_HEIGHT) : off_w;
		row_sum  = SUM_W'(base_mod) + off_mod;
		row_wrap = (row_sum >= SUM_W'(FRAME_HEIGHT)) ? row_sum - SUM_W'(FRAME_HEIGHT)
			: row_sum;
		if (operation == OP_READ) begin
			row = base_mod;
		end else begin
			row = ROW_W'(row_wrap);
		end
	end

	logic [COL_W-1:0] col_mod;
	logic [POS_W-1:0] pos;

	// Place each set sprite pixel at its wrapped column; leftmost is the MSB
	always_comb begin
		col_mod = col_tbl[column];
		mask    = '0;
		pos     = '0;
		for (int px = 0; px < SPRITE_W; px++) begin
			pos = POS_W'(col_mod) + POS_W'(px);
			if (pos >= POS_W'(FRAME_WIDTH)) begin
				pos = pos - POS_W'(FRAME_WIDTH);
			end
			if (sprite_bits[SPRITE_W-1-px]) begin
				mask[pos[COL_W-1:0]] = 1'b1;
			end
		end
	end

endmodule

FILE: src/xor_sprite_framebuffer.sv
// Top level of the XOR sprite framebuffer: row memory, read-modify-write stage, result register.
//
// One word in on the input channel (in_valid / in_stall) gives one word out on the
// output channel (out_valid / out_stall). operation selects clear, draw one sprite
// row, or read one frame row. A draw XORs eight sprite pixels into the wrapped row
// and reports the collision flag accumulated over the sprite; the flag clears after
// a draw marked last_row. A read returns the row with bit 0 as the leftmost pixel.
// An accepted word passes through the stage 1 register, then the result register.
// Throughput: one word per cycle while out_stall is low. Each word reads its row
// from the frame memory at acceptance and writes it back as it leaves stage 1; a
// word that hits the row being written back takes the new contents by forwarding,
// so back-to-back draws on one row need no wait.
// Reset: the frame reads as all pixels off through per-row valid bits, no clearing
// pass; the collision flag is zero. A clear word drops all row valid bits at once.
// When out_stall holds a result, the stage behind it holds at most one more word;
// once that stage is full, in_stall rises until the result is taken.
module xor_sprite_framebuffer import xsfb_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [COORD_W-1:0]   column,
	input  logic [COORD_W-1:0]   base_row,
	input  logic [OFFSET_W-1:0]  row_offset,
	input  logic [SPRITE_W-1:0]  sprite_bits,
	input  logic                 last_row,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 collision,
	output logic [PIXELS_W-1:0]  row_pixels
);

	localparam int ROW_W = $clog2(FRAME_HEIGHT);

	logic adv_out;
	logic s1_take;
	logic accept;
	logic retire;

	logic                   v_s1;
	op_t                    op_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [FRAME_WIDTH-1:0] mask_s1;
	logic                   last_s1;
	logic                   fwd_s1;
	logic                   vld_s1;
	logic [FRAME_WIDTH-1:0] fwd_line_s1;

	logic                    out_valid_q;
	logic                    collision_q;
	logic [PIXELS_W-1:0]     row_pixels_q;
	logic                    coll_q;
	logic [FRAME_HEIGHT-1:0] row_vld_q;

	logic [ROW_W-1:0]       row_a;
	logic [FRAME_WIDTH-1:0] mask_a;
	logic [FRAME_WIDTH-1:0] ram_rdata;
	logic [FRAME_WIDTH-1:0] line_cur;
	logic [FRAME_WIDTH-1:0] line_new;
	logic                   hit;
	logic                   flag;
	logic                   fwd_d;
	logic                   vld_d;
	logic                   collision_d;
	logic [PIXELS_W-1:0]    row_pixels_d;

	// Handshake: stage 1 retires when the result register is free or being taken
	assign adv_out  = !out_valid_q || !out_stall;
	assign s1_take  = !v_s1 || adv_out;
	assign in_stall = !s1_take;
	assign accept   = in_valid && s1_take;
	assign retire   = v_s1 && adv_out;

	xsfb_addr #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_addr (
		.operation  (op_t'(operation)),
		.column     (column),
		.base_row   (base_row),
		.row_offset (row_offset),
		.sprite_bits(sprite_bits),
		.row        (row_a),
		.mask       (mask_a)
	);

	xsfb_ram #(
		.WIDTH(FRAME_WIDTH),
		.DEPTH(FRAME_HEIGHT)
	) u_frame (
		.clk  (clk),
		.we   (retire && (op_s1 == OP_DRAW)),
		.waddr(row_s1),
		.wdata(line_new),
		.re   (accept),
		.raddr(row_a),
		.rdata(ram_rdata)
	);

	// Select the row source: forwarded write, memory, or cleared
	always_comb begin
		fwd_d = 1'b0;
		vld_d = row_vld_q[row_a];
		if (retire && (op_s1 == OP_CLEAR)) begin
			vld_d = 1'b0;
		end else if (retire && (op_s1 == OP_DRAW) && (row_s1 == row_a)) begin
			fwd_d = 1'b1;
		end
	end

	// Modify the row in stage 1
	always_comb begin
		if (fwd_s1) begin
			line_cur = fwd_line_s1;
		end else if (vld_s1) begin
			line_cur = ram_rdata;
		end else begin
			line_cur = '0;
		end
		line_new = line_cur ^ mask_s1;
		hit      = |(line_cur & mask_s1);
		flag     = coll_q || hit;
	end

	// Form the result word
	always_comb begin
		collision_d  = 1'b0;
		row_pixels_d = '0;
		case (op_s1)
			OP_DRAW: begin
				collision_d = flag;
			end
			OP_READ: begin
				row_pixels_d = PIXELS_W'(line_cur);
			end
			default: begin
				collision_d  = 1'b0;
				row_pixels_d = '0;
			end
		endcase
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_take) begin
			v_s1 <= in_valid;
		end
	end

	// Stage 1 payload, capture on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_t'(operation);
			row_s1      <= row_a;
			mask_s1     <= mask_a;
			last_s1     <= last_row;
			fwd_s1      <= fwd_d;
			vld_s1      <= vld_d;
			fwd_line_s1 <= line_new;
		end
	end

	// Frame row valid bits and collision accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			coll_q    <= 1'b0;
		end else if (retire) begin
			case (op_s1)
				OP_CLEAR: begin
					row_vld_q <= '0;
				end
				OP_DRAW: begin
					row_vld_q[row_s1] <= 1'b1;
					coll_q            <= last_s1 ? 1'b0 : flag;
				end
				default: begin
					coll_q <= coll_q;
				end
			endcase
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s1;
		end
	end

	// Result register payload, hold while stalled
	always_ff @(posedge clk) begin
		if (retire) begin
			collision_q  <= collision_d;
			row_pixels_q <= row_pixels_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign collision  = collision_q;
	assign row_pixels = row_pixels_q;

endmodule

FILE: test/xsfb_checker.sv
// Result checker for the XOR sprite framebuffer: predicts every result word and compares it.
`timescale 1ns / 1ps

module xsfb_checker import xsfb_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [COORD_W-1:0]   column,
	input  logic [COORD_W-1:0]   base_row,
	input  logic [OFFSET_W-1:0]  row_offset,
	input  logic [SPRITE_W-1:0]  sprite_bits,
	input  logic                 last_row,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 collision,
	input  logic [PIXELS_W-1:0]  row_pixels,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic                collision;
		logic [PIXELS_W-1:0] row_pixels;
	} frame_result_t;

	// shadow copy of the frame and the collision flag of the sprite in progress
	logic [PIXELS_W-1:0] frame_img [FRAME_HEIGHT];
	logic                sprite_hit;
	frame_result_t       expected_q [$];

	// apply one input word to the shadow frame, return the word the block should give back
	function automatic frame_result_t apply_word(
		logic [OP_W-1:0]     op,
		logic [COORD_W-1:0]  col,
		logic [COORD_W-1:0]  brow,
		logic [OFFSET_W-1:0] roff,
		logic [SPRITE_W-1:0] bits,
		logic                last
	);
		frame_result_t       res;
		logic [PIXELS_W-1:0] line;
		int                  row;
		int                  x;
		res = '0;
		case (op)
			OP_CLEAR: begin
				// flag of a sprite in progress survives a clear
				foreach (frame_img[r])
					frame_img[r] = '0;
			end
			OP_DRAW: begin
				row = (int'(brow) + int'(roff)) % FRAME_HEIGHT;
				line = frame_img[row];
				// leftmost sprite pixel is the top bit; columns wrap to the left edge
				for (int px = 0; px < SPRITE_W; px++) begin
					if (bits[SPRITE_W-1-px]) begin
						x = (int'(col) + px) % FRAME_WIDTH;
						if (line[x])
							sprite_hit = 1'b1;
						line[x] = ~line[x];
					end
				end
				frame_img[row] = line;
				res.collision = sprite_hit;
				if (last)
					sprite_hit = 1'b0;
			end
			OP_READ: begin
				res.row_pixels = frame_img[int'(brow) % FRAME_HEIGHT];
			end
			default: begin
				// unused code: nothing changes, all zero back
			end
		endcase
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [PIXELS_W-1:0] want, logic [PIXELS_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	// match each taken result word against the oldest prediction, then log the new input word
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			foreach (frame_img[r])
				frame_img[r] = '0;
			sprite_hit = 1'b0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with nothing expected", $time);
				end else begin
					want = expected_q.pop_front();
					if (collision !== want.collision)
						note_mismatch("collision", PIXELS_W'(want.collision), PIXELS_W'(collision));
					if (row_pixels !== want.row_pixels)
						note_mismatch("row_pixels", want.row_pixels, row_pixels);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(apply_word(operation, column, base_row, row_offset,
					sprite_bits, last_row));
			pending = expected_q.size();
		end
	end

endmodule

FILE: test/tb.sv
// Testbench top for the XOR sprite framebuffer: clock, reset, word stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb;
	import xsfb_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS  = 1100;
	localparam int SQUEEZE_AT    = 500;   // word count where the long output hold-off starts
	localparam int SQUEEZE_SPAN  = 100;   // words offered back to back from it on
	localparam int SQUEEZE_LEN   = 300;   // cycles the output side holds off
	localparam int SWITCH_EVERY  = 60;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [COORD_W-1:0]  column;
	logic [COORD_W-1:0]  base_row;
	logic [OFFSET_W-1:0] row_offset;
	logic [SPRITE_W-1:0] sprite_bits;
	logic                last_row;
	logic                out_valid;
	logic                out_stall;
	logic                collision;
	logic [PIXELS_W-1:0] row_pixels;

	int fail_count;
	int pending;
	int words_sent;
	bit sender_idles;
	bit receiver_idles;
	bit squeeze_req;
	bit squeeze_done;

	xor_sprite_framebuffer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.column      (column),
		.base_row    (base_row),
		.row_offset  (row_offset),
		.sprite_bits (sprite_bits),
		.last_row    (last_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.collision   (collision),
		.row_pixels  (row_pixels)
	);

	xsfb_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.column      (column),
		.base_row    (base_row),
		.row_offset  (row_offset),
		.sprite_bits (sprite_bits),
		.last_row    (last_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.collision   (collision),
		.row_pixels  (row_pixels),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// offer one word, after a random gap if the sender idles, and hold it until the block takes it
	task automatic send_word(
		logic [OP_W-1:0]     op,
		logic [COORD_W-1:0]  col,
		logic [COORD_W-1:0]  brow,
		logic [OFFSET_W-1:0] roff,
		logic [SPRITE_W-1:0] bits,
		logic                last
	);
		int gap;
		gap = sender_idles ? $urandom_range(0, 15) : 0;
		if (words_sent >= SQUEEZE_AT && words_sent < SQUEEZE_AT + SQUEEZE_SPAN)
			gap = 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (words_sent == SQUEEZE_AT)
			squeeze_req = 1'b1;
		operation   = op;
		column      = col;
		base_row    = brow;
		row_offset  = roff;
		sprite_bits = bits;
		last_row    = last;
		in_valid    = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		@(negedge clk);
		words_sent++;
	endtask

	// output side: random hold-off before each word when idling, one long hold-off on request
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				hold = SQUEEZE_LEN;
				squeeze_done = 1'b1;
			end else begin
				hold = receiver_idles ? $urandom_range(0, 15) : 0;
			end
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			forever begin
				@(posedge clk);
				if (out_valid)
					break;
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int                  pick;
		int                  span;
		int                  next_switch;
		int                  stop_at;
		int                  sp_rows;
		bit                  have_sprite;
		logic [COORD_W-1:0]  sp_col;
		logic [COORD_W-1:0]  sp_row;
		logic [SPRITE_W-1:0] sp_img [16];
		logic [COORD_W-1:0]  scan_row;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_CLEAR;
		column      = '0;
		base_row    = '0;
		row_offset  = '0;
		sprite_bits = '0;
		last_row    = 1'b0;
		have_sprite = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: fresh frame, wrap in both directions, flag accumulation, clear, unused code
		send_word(OP_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
		send_word(OP_READ,   8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
		send_word(OP_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b0);
		send_word(OP_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
		send_word(OP_DRAW,   8'd0,   8'd0,   4'd0,  8'h80, 1'b1);
		send_word(OP_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
		send_word(OP_DRAW,   8'd60,  8'd30,  4'd15, 8'hFF, 1'b1);
		send_word(OP_READ,   8'd17,  8'd45,  4'd9,  8'h3C, 1'b0);
		send_word(OP_DRAW,   8'd255, 8'd255, 4'd15, 8'h81, 1'b1);
		send_word(OP_READ,   8'd0,   8'd14,  4'd0,  8'h00, 1'b1);
		send_word(OP_DRAW,   8'd0,   8'd0,   4'd0,  8'h80, 1'b0);
		send_word(OP_DRAW,   8'd8,   8'd0,   4'd1,  8'h01, 1'b0);
		send_word(OP_CLEAR,  8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
		send_word(OP_DRAW,   8'd16,  8'd0,   4'd2,  8'hAA, 1'b1);
		send_word(OP_DRAW,   8'd16,  8'd0,   4'd2,  8'h55, 1'b1);
		send_word(OP_UNUSED, 8'd200, 8'd77,  4'd5,  8'hC3, 1'b1);
		send_word(OP_READ,   8'd0,   8'd2,   4'd0,  8'h00, 1'b0);
		send_word(OP_DRAW,   8'd33,  8'd9,   4'd3,  8'h00, 1'b1);
		send_word(OP_DRAW,   8'd128, 8'd128, 4'd0,  8'hFF, 1'b1);
		send_word(OP_READ,   8'd0,   8'd128, 4'd0,  8'h00, 1'b0);
		send_word(OP_CLEAR,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
		send_word(OP_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0);

		// random: mostly whole sprites and row scans, some broken sprites and noise
		stop_at = words_sent + RANDOM_WORDS;
		next_switch = words_sent;
		while (words_sent < stop_at) begin
			if (words_sent >= next_switch) begin
				{sender_idles, receiver_idles} = 2'($urandom_range(0, 3));
				next_switch = words_sent + SWITCH_EVERY;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// new sprite, or redraw the last one to erase it and collide on every row
				if (!have_sprite || $urandom_range(0, 3) != 0) begin
					sp_col  = 8'($urandom_range(0, 255));
					sp_row  = 8'($urandom_range(0, 255));
					sp_rows = $urandom_range(1, 16);
					foreach (sp_img[i])
						sp_img[i] = 8'($urandom_range(0, 255));
					have_sprite = 1'b1;
				end
				for (int i = 0; i < sp_rows; i++)
					send_word(OP_DRAW, sp_col, sp_row, 4'(i), sp_img[i], i == sp_rows - 1);
			end else if (pick < 75) begin
				scan_row = 8'($urandom_range(0, 255));
				span = $urandom_range(1, 8);
				for (int k = 0; k < span; k++) begin
					send_word(OP_READ, 8'($urandom_range(0, 255)), scan_row,
						4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					scan_row++;
				end
			end else if (pick < 85) begin
				// broken sprite: random offsets, last flag anywhere or missing
				span = $urandom_range(1, 4);
				for (int k = 0; k < span; k++)
					send_word(OP_DRAW, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end else if (pick < 88) begin
				send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (pick < 93) begin
				send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				send_word(OP_W'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		// drain, then wait for any stray word before the verdict
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
